[src/kmse_pkg.sv]
// ----------------------------------------------------------------------------
// kmse_pkg - shared types and constants of the keyboard matrix scan encoder
// Keymap table, action and layer codes, register indexes and report layout.
// ----------------------------------------------------------------------------
package kmse_pkg;

  localparam int MAP_ROWS     = 5;
  localparam int MAP_COLS     = 18;
  localparam int MAP_SIZE     = MAP_ROWS * MAP_COLS;
  localparam int REPORT_SLOTS = 6;
  localparam int CODE_W       = 8;
  localparam int COUNT_W      = 3;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;
  localparam int IN_DATA_W    = 16;
  localparam int OUT_DATA_W   = 64;

  // action field of a keymap entry
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_KEY  = 2'd1;
  localparam logic [1:0] ACT_MOD  = 2'd2;

  // keymap layers
  localparam logic [1:0] LAYER_BASE = 2'd0;
  localparam logic [1:0] LAYER_ONE  = 2'd1;
  localparam logic [1:0] LAYER_TWO  = 2'd2;

  typedef enum logic [2:0] {
    REG_FN_ROW,
    REG_FN_COL,
    REG_FN2_ROW,
    REG_FN2_COL,
    REG_SHIFT_ROW,
    REG_SHIFT_COL
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        act;
    logic [CODE_W-1:0] code;
  } map_entry_t;

  // base layer, row by row, {action, code}
  localparam logic [9:0] KEYMAP_BASE [MAP_SIZE] = '{
    10'h129, 10'h126, 10'h127, 10'h11E, 10'h122, 10'h124, 10'h000, 10'h123, 10'h11F,
    10'h120, 10'h125, 10'h121, 10'h14C, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h139, 10'h10D, 10'h109, 10'h110, 10'h113, 10'h119, 10'h000, 10'h133, 10'h135,
    10'h11D, 10'h138, 10'h134, 10'h131, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h204, 10'h115, 10'h116, 10'h111, 10'h107, 10'h105, 10'h000, 10'h12D, 10'h104,
    10'h108, 10'h10C, 10'h10B, 10'h114, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h000, 10'h000, 10'h10A, 10'h10F, 10'h106, 10'h11A, 10'h12A, 10'h12E, 10'h118,
    10'h112, 10'h11C, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
    10'h201, 10'h11B, 10'h136, 10'h137, 10'h202, 10'h12C, 10'h12B, 10'h117, 10'h128,
    10'h12F, 10'h130, 10'h10E, 10'h1E3, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000
  };

  // keymap lookup: base entry, with the code replaced on the fn layers
  function automatic map_entry_t keymap_entry(input logic [1:0] layer,
                                              input logic [2:0] row,
                                              input logic [4:0] col);
    map_entry_t  e;
    logic        hit;
    logic [7:0]  p1;
    logic [7:0]  p2;
    e   = '0;
    hit = 1'b0;
    p1  = '0;
    p2  = '0;
    if (int'(row) < MAP_ROWS && int'(col) < MAP_COLS) begin
      e = map_entry_t'(KEYMAP_BASE[7'(int'(row) * MAP_COLS + int'(col))]);
    end
    unique case ({row, col})
      {3'd0, 5'd0}:  begin hit = 1'b1; p1 = 8'h44; p2 = 8'h44; end
      {3'd0, 5'd1}:  begin hit = 1'b1; p1 = 8'h42; p2 = 8'h42; end
      {3'd0, 5'd2}:  begin hit = 1'b1; p1 = 8'h43; p2 = 8'h43; end
      {3'd0, 5'd3}:  begin hit = 1'b1; p1 = 8'h3A; p2 = 8'h3A; end
      {3'd0, 5'd4}:  begin hit = 1'b1; p1 = 8'h3E; p2 = 8'h3E; end
      {3'd0, 5'd5}:  begin hit = 1'b1; p1 = 8'h40; p2 = 8'h40; end
      {3'd0, 5'd7}:  begin hit = 1'b1; p1 = 8'h3F; p2 = 8'h3F; end
      {3'd0, 5'd8}:  begin hit = 1'b1; p1 = 8'h3B; p2 = 8'h3B; end
      {3'd0, 5'd9}:  begin hit = 1'b1; p1 = 8'h3C; p2 = 8'h3C; end
      {3'd0, 5'd10}: begin hit = 1'b1; p1 = 8'h41; p2 = 8'h41; end
      {3'd0, 5'd11}: begin hit = 1'b1; p1 = 8'h3D; p2 = 8'h3D; end
      {3'd0, 5'd12}: begin hit = 1'b1; p1 = 8'h45; p2 = 8'h45; end
      {3'd1, 5'd4}:  begin hit = 1'b1; p1 = 8'h46; p2 = 8'h46; end
      {3'd4, 5'd9}:  begin hit = 1'b1; p1 = 8'h80; p2 = 8'h80; end
      {3'd4, 5'd10}: begin hit = 1'b1; p1 = 8'h81; p2 = 8'h81; end
      // arrows on layer one, home/end/page keys on layer two
      {3'd4, 5'd2}:  begin hit = 1'b1; p1 = 8'h50; p2 = 8'h4A; end
      {3'd4, 5'd3}:  begin hit = 1'b1; p1 = 8'h51; p2 = 8'h4E; end
      {3'd3, 5'd4}:  begin hit = 1'b1; p1 = 8'h4F; p2 = 8'h4D; end
      {3'd3, 5'd3}:  begin hit = 1'b1; p1 = 8'h52; p2 = 8'h4B; end
      default: ;
    endcase
    if (hit && layer == LAYER_ONE) begin
      e.code = p1;
    end else if (hit && layer == LAYER_TWO) begin
      e.code = p2;
    end
    return e;
  endfunction

endpackage

[src/kmse_ram.sv]
// ----------------------------------------------------------------------------
// kmse_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kmse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 90,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/keyboard_matrix_scan_encoder.sv]
// ----------------------------------------------------------------------------
// keyboard_matrix_scan_encoder - matrix scan to six-key HID report encoder
// Debounces raw matrix samples in a history RAM, looks up the layered keymap
// and builds one report per scan with keys down, or a single empty report on going idle.
// ----------------------------------------------------------------------------
//  channel   dir   handshake              payload
//  s_axis    in    tvalid/tready          tdata {level, col, row}, tlast end of scan
//  m_axis    out   tvalid/tready          tdata {count, codes 5..0, modifiers}
//  apb       in    psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
//  One sample per cycle. A sample reads its history at acceptance and writes
//  it back from the work stage; a back-to-back hit on the same position is
//  forwarded from the last write. The end-of-scan beat holds in the work
//  stage only while a previous report is still waiting on m_axis. Reset clears
//  the history valid bits at once: there is no clearing pass.
module keyboard_matrix_scan_encoder #(
  parameter int ROWS         = 5,
  parameter int COLS         = 18,
  parameter int MAX_KEYS     = 6,
  parameter int HISTORY_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave stream: sample beats
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [kmse_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // row[2:0], col[7:3], level[8]
  input  logic                              s_axis_tlast,
  // master stream: report beats
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // modifiers[7:0], key_code_0..5 [55:8], key_count[58:56]
  output logic [kmse_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kmse_pkg::PADDR_W-1:0]      paddr,
  input  logic [kmse_pkg::PDATA_W-1:0]      pwdata,
  output logic [kmse_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int NPOS = ROWS * COLS;
  localparam int AW   = (NPOS > 1) ? $clog2(NPOS) : 1;
  localparam int HW   = HISTORY_BITS;
  localparam int CW   = kmse_pkg::CODE_W;
  localparam int NW   = kmse_pkg::COUNT_W;
  localparam int NS   = kmse_pkg::REPORT_SLOTS;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [2:0] fn_row_q, fn2_row_q, sh_row_q;
  logic [4:0] fn_col_q, fn2_col_q, sh_col_q;
  logic       cfg_wr;
  logic [2:0] cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_row_q  <= 3'd2;
      fn_col_q  <= 5'd6;
      fn2_row_q <= 3'd1;
      fn2_col_q <= 5'd6;
      sh_row_q  <= 3'd4;
      sh_col_q  <= 5'd4;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        kmse_pkg::REG_FN_ROW:    fn_row_q  <= pwdata[2:0];
        kmse_pkg::REG_FN_COL:    fn_col_q  <= pwdata[4:0];
        kmse_pkg::REG_FN2_ROW:   fn2_row_q <= pwdata[2:0];
        kmse_pkg::REG_FN2_COL:   fn2_col_q <= pwdata[4:0];
        kmse_pkg::REG_SHIFT_ROW: sh_row_q  <= pwdata[2:0];
        kmse_pkg::REG_SHIFT_COL: sh_col_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      kmse_pkg::REG_FN_ROW:    prdata = 32'(fn_row_q);
      kmse_pkg::REG_FN_COL:    prdata = 32'(fn_col_q);
      kmse_pkg::REG_FN2_ROW:   prdata = 32'(fn2_row_q);
      kmse_pkg::REG_FN2_COL:   prdata = 32'(fn2_col_q);
      kmse_pkg::REG_SHIFT_ROW: prdata = 32'(sh_row_q);
      kmse_pkg::REG_SHIFT_COL: prdata = 32'(sh_col_q);
      default:                 prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // accept stage: issue the history read
  // --------------------------------------------------------------------------
  logic [2:0]    in_row;
  logic [4:0]    in_col;
  logic          in_level;
  logic          in_inm;
  logic [AW-1:0] in_addr;
  logic          accept;

  assign in_row   = s_axis_tdata[2:0];
  assign in_col   = s_axis_tdata[7:3];
  assign in_level = s_axis_tdata[8];
  assign in_inm   = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
  assign in_addr  = in_inm ? AW'(32'(in_row) * COLS + 32'(in_col)) : '0;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // work stage registers
  logic          s1_valid_q;
  logic [2:0]    s1_row_q;
  logic [4:0]    s1_col_q;
  logic          s1_level_q;
  logic          s1_inm_q;
  logic          s1_last_q;
  logic [AW-1:0] s1_addr_q;
  logic          s1_adv;

  // hold the end-of-scan beat while the output register is still occupied
  assign s1_adv        = s1_valid_q && !(s1_last_q && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_row_q   <= in_row;
      s1_col_q   <= in_col;
      s1_level_q <= in_level;
      s1_inm_q   <= in_inm;
      s1_last_q  <= s_axis_tlast;
      s1_addr_q  <= in_addr;
    end
  end

  // --------------------------------------------------------------------------
  // history RAM with valid and down bits per position
  // --------------------------------------------------------------------------
  logic [HW-1:0]   ram_rdata;
  logic [HW-1:0]   hist_old;
  logic [HW-1:0]   hist_new;
  logic            down_now;
  logic            hist_we;
  logic [NPOS-1:0] hvalid_q;
  logic [NPOS-1:0] down_q;
  logic            fwd_valid_q;
  logic [AW-1:0]   fwd_addr_q;
  logic [HW-1:0]   fwd_data_q;
  logic            fwd_hit;

  kmse_ram #(
    .WIDTH (HW),
    .DEPTH (NPOS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (s1_addr_q),
    .wdata_i (hist_new),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign fwd_hit  = fwd_valid_q && (fwd_addr_q == s1_addr_q);
  assign hist_old = fwd_hit ? fwd_data_q : (hvalid_q[s1_addr_q] ? ram_rdata : '0);
  assign hist_new = HW'({hist_old, s1_level_q});
  assign down_now = |hist_new;
  assign hist_we  = s1_adv && s1_inm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q    <= '0;
      down_q      <= '0;
      fwd_valid_q <= 1'b0;
    end else if (s1_adv) begin
      // the next beat read the RAM at this edge: keep this write for it
      fwd_valid_q <= s1_inm_q;
      if (s1_inm_q) begin
        hvalid_q[s1_addr_q] <= 1'b1;
        down_q[s1_addr_q]   <= down_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fwd_addr_q <= s1_addr_q;
      fwd_data_q <= hist_new;
    end
  end

  // --------------------------------------------------------------------------
  // keymap lookup and report accumulation
  // --------------------------------------------------------------------------
  logic                 fn_held_q, fn_lock_q, fn2_held_q, fn2_lock_q, idle_sent_q;
  logic [1:0]           layer;
  kmse_pkg::map_entry_t entry;
  logic                 hit_key;
  logic                 add_key;
  logic [CW-1:0]        mod_q, mod_d;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        codes_q [NS];
  logic [CW-1:0]        codes_d [NS];
  logic                 report_full;
  logic                 emit;

  always_comb begin
    if ((fn_lock_q && fn2_lock_q) || (fn_held_q && fn2_held_q)) begin
      layer = kmse_pkg::LAYER_TWO;
    end else if (fn_lock_q || fn2_lock_q || fn_held_q || fn2_held_q) begin
      layer = kmse_pkg::LAYER_ONE;
    end else begin
      layer = kmse_pkg::LAYER_BASE;
    end
  end

  assign entry   = kmse_pkg::keymap_entry(layer, s1_row_q, s1_col_q);
  assign hit_key = s1_inm_q && down_now;
  assign add_key = hit_key && (entry.act == kmse_pkg::ACT_KEY) && (32'(cnt_q) < MAX_KEYS);

  always_comb begin
    mod_d   = mod_q;
    cnt_d   = cnt_q;
    codes_d = codes_q;
    if (hit_key && entry.act == kmse_pkg::ACT_MOD) begin
      mod_d = mod_q | entry.code;
    end
    if (add_key) begin
      codes_d[cnt_q] = entry.code;
      cnt_d          = cnt_q + NW'(1);
    end
  end

  assign report_full = (cnt_d != '0) || (mod_d != '0);
  assign emit        = report_full || !idle_sent_q;

  // fn and shift key state as of this beat
  logic [2:0]    krow [3];
  logic [4:0]    kcol [3];
  logic [2:0]    kdown;

  assign krow[0] = fn_row_q;
  assign kcol[0] = fn_col_q;
  assign krow[1] = fn2_row_q;
  assign kcol[1] = fn2_col_q;
  assign krow[2] = sh_row_q;
  assign kcol[2] = sh_col_q;

  always_comb begin
    logic          kin;
    logic [AW-1:0] kidx;
    for (int k = 0; k < 3; k++) begin
      kin  = (32'(krow[k]) < ROWS) && (32'(kcol[k]) < COLS);
      kidx = kin ? AW'(32'(krow[k]) * COLS + 32'(kcol[k])) : '0;
      if (!kin) begin
        kdown[k] = 1'b0;
      end else if (s1_inm_q && kidx == s1_addr_q) begin
        kdown[k] = down_now;
      end else begin
        kdown[k] = down_q[kidx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= '0;
      cnt_q       <= '0;
      codes_q     <= '{default: '0};
      fn_held_q   <= 1'b0;
      fn_lock_q   <= 1'b0;
      fn2_held_q  <= 1'b0;
      fn2_lock_q  <= 1'b0;
      idle_sent_q <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        mod_q   <= '0;
        cnt_q   <= '0;
        codes_q <= '{default: '0};
        // shift held on a fresh fn press toggles that fn lock
        if (kdown[2] && kdown[0] && !fn_held_q) begin
          fn_lock_q <= !fn_lock_q;
        end
        if (kdown[2] && kdown[1] && !fn2_held_q) begin
          fn2_lock_q <= !fn2_lock_q;
        end
        fn_held_q   <= kdown[0];
        fn2_held_q  <= kdown[1];
        idle_sent_q <= !report_full;
      end else begin
        mod_q   <= mod_d;
        cnt_q   <= cnt_d;
        codes_q <= codes_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic                          out_valid_q;
  logic [kmse_pkg::OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // an empty report carries zeros, which the cleared accumulators already hold
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q && emit) begin
      out_data_q <= {5'b0, cnt_d, codes_d[5], codes_d[4], codes_d[3], codes_d[2],
                     codes_d[1], codes_d[0], mod_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[58:56]) <= MAX_KEYS))
    else $error("report key count above limit");

  a_unused_slots_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[58:56] == 3'd0) |-> (m_axis_tdata[55:8] == '0))
    else $error("empty report carries key codes");

  a_hold_only_on_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (s1_last_q && m_axis_tvalid && !m_axis_tready))
    else $error("work stage held without output backpressure");

  a_fwd_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_we |=> (fwd_valid_q && fwd_addr_q == $past(s1_addr_q)))
    else $error("history forward register missed a write");

endmodule
